>>> src/roll_pitch_yaw_to_rotation_matrix_macros.svh
// Assertion macros for the rotation matrix RTL.
// Included by the top level, which carries concurrent assertions; no other dependencies.
`ifndef ROLL_PITCH_YAW_TO_ROTATION_MATRIX_MACROS_SVH
`define ROLL_PITCH_YAW_TO_ROTATION_MATRIX_MACROS_SVH

// Property that must hold whenever the reset is released.
`define RPY_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define RPY_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> src/rpy_pkg.sv
// Package for the rotation matrix block: fixed-point constants, widths and helpers.
// No dependencies.
`default_nettype none
package rpy_pkg;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int OUT_W          = 16;
    localparam int NUM_OUT        = 9;
    localparam int SERIES_TERMS   = 8;
    localparam int MAG_W          = 32;
    localparam int SIG_W          = 33;
    // Registers along one sine chain: scale, square, two per series step, final product.
    localparam int CHAIN_LAT      = 2 * SERIES_TERMS + 3;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;

    typedef logic signed [SIG_W-1:0] q30_t;

    // Cell operation codes.
    typedef enum logic [1:0] {
        OP_SCALE  = 2'd0,
        OP_SQUARE = 2'd1,
        OP_SERIES = 2'd2,
        OP_FINISH = 2'd3
    } cell_op_t;

    // Divisor 2k(2k+1) for series step k.
    function automatic logic [8:0] series_div(input logic [3:0] k);
        logic [8:0] r;
        begin
            case (k)
                4'd1: r = 9'd6;
                4'd2: r = 9'd20;
                4'd3: r = 9'd42;
                4'd4: r = 9'd72;
                4'd5: r = 9'd110;
                4'd6: r = 9'd156;
                4'd7: r = 9'd210;
                4'd8: r = 9'd272;
                default: r = 9'd1;
            endcase
            series_div = r;
        end
    endfunction

    // Magnitude of a signed Q2.30 value.
    function automatic logic [MAG_W-1:0] mag(input q30_t v);
        logic [SIG_W-1:0] n;
        begin
            n = v[SIG_W-1] ? (-v) : v;
            mag = n[MAG_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> src/rpy_sine_cell.sv
// One stage of the quarter-sine chain: scale, square, one series step or final product.
// Depends on rpy_pkg.
`default_nettype none
module rpy_sine_cell #(
    parameter rpy_pkg::cell_op_t OP = rpy_pkg::OP_SCALE,
    parameter int              K  = 1
) (
    input  wire                 clk,
    input  wire                 en,
    input  wire [31:0]          x_in,
    input  wire [31:0]          x2_in,
    input  wire [31:0]          v_in,
    output logic [31:0]         x_out,
    output logic [31:0]         x2_out,
    output logic [31:0]         v_out
);
    import rpy_pkg::*;

    logic [31:0] x_next, x2_next, v_next;
    logic [31:0] x_reg, x2_reg, v_reg;

    generate
        if (OP == OP_SERIES)
        begin : g_series
            localparam int          DIV    = int'(series_div(4'(K)));
            localparam int          DIV_SH = 32 + $clog2(DIV);
            localparam logic [32:0] RECIP  =
                33'(((65'd1 << DIV_SH) + 65'(DIV - 1)) / 65'(DIV));
            logic [63:0] prod;
            logic [64:0] qprod;
            logic [31:0] term;
            logic [31:0] xa_reg, x2a_reg, q_reg;

            // First cycle: product of the square and the running series value.
            assign prod = 64'(x2_in) * 64'(v_in);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    xa_reg  <= x_in;
                    x2a_reg <= x2_in;
                    q_reg   <= prod[61:30];
                end
            end

            // Second cycle: truncating division by 2k(2k+1) as a reciprocal multiplication.
            assign qprod   = 65'(q_reg) * 65'(RECIP);
            assign term    = 32'(qprod >> DIV_SH);
            assign x_next  = xa_reg;
            assign x2_next = x2a_reg;
            assign v_next  = (term > Q30_ONE) ? 32'd0 : (Q30_ONE - term);
        end
        else
        begin : g_single
            logic [63:0] prod;

            // One multiplier per cell.
            always_comb
            begin
                x_next  = x_in;
                x2_next = x2_in;
                v_next  = v_in;
                case (OP)
                    OP_SCALE:
                    begin
                        prod   = 64'(x_in) * 64'(HALF_PI_Q30);
                        x_next = prod[61:30];
                        v_next = Q30_ONE;
                    end
                    OP_SQUARE:
                    begin
                        prod    = 64'(x_in) * 64'(x_in);
                        x2_next = prod[61:30];
                    end
                    default:
                    begin
                        prod   = 64'(x_in) * 64'(v_in);
                        v_next = prod[61:30];
                    end
                endcase
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            x2_reg <= x2_next;
            v_reg  <= v_next;
        end
    end

    assign x_out  = x_reg;
    assign x2_out = x2_reg;
    assign v_out  = v_reg;
endmodule
`default_nettype wire

>>> src/rpy_sine_chain.sv
// Chain of cells computing sine of a quarter-turn offset t in [0, 2^30].
// Depends on rpy_pkg and rpy_sine_cell.
`default_nettype none
module rpy_sine_chain (
    input  wire          clk,
    input  wire          en,
    input  wire [31:0]   t,
    output logic [31:0]  sine
);
    import rpy_pkg::*;

    localparam int N = SERIES_TERMS + 3;

    logic [31:0] xs [N+1];
    logic [31:0] x2s [N+1];
    logic [31:0] vs [N+1];

    assign xs[0]  = t;
    assign x2s[0] = '0;
    assign vs[0]  = '0;

    // Scale, square, eight series steps from k = 8 down, final product.
    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            localparam cell_op_t CO = (i == 0) ? OP_SCALE :
                                      (i == 1) ? OP_SQUARE :
                                      (i == N-1) ? OP_FINISH : OP_SERIES;
            rpy_sine_cell #(.OP(CO), .K(SERIES_TERMS + 2 - i)) u_cell (
                .clk(clk), .en(en),
                .x_in(xs[i]), .x2_in(x2s[i]), .v_in(vs[i]),
                .x_out(xs[i+1]), .x2_out(x2s[i+1]), .v_out(vs[i+1])
            );
        end
    endgenerate

    assign sine = vs[N];
endmodule
`default_nettype wire

>>> src/roll_pitch_yaw_to_rotation_matrix.sv
// Top level of the Euler angle (roll, pitch, yaw) to rotation matrix pipeline.
// Depends on rpy_pkg, rpy_sine_chain and the assertion macro header.
`default_nettype none
`include "roll_pitch_yaw_to_rotation_matrix_macros.svh"
// Fully pipelined: one word accepted per cycle, through 1 quadrant stage, the
// sine chain registers for scale, square, eight series steps and the final product,
// 2 product stages, 1 sum stage and 1 output register. The whole
// pipe advances when the output register is empty or being read, so a stalled
// output stops every stage; throughput stays at one word per cycle while the
// consumer keeps up. Results are Q1.14 saturated to +/-16384.
module roll_pitch_yaw_to_rotation_matrix #(
    parameter int ANGLE_BITS = rpy_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = rpy_pkg::FRAC_BITS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
    input  wire [47:0]   s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // row0_col0 [15:0], row1_col0 [31:16] up to row2_col2 [143:128], column-major
    output logic [143:0] m_tdata
);
    import rpy_pkg::*;

    localparam int LAT = CHAIN_LAT + 5;

    logic        adv;
    logic [LAT-1:0] vld_reg, vld_next;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Valid bits along the pipe.
    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], s_tvalid};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end
    assign m_tvalid = vld_reg[LAT-1];

    // Quadrant split per angle.
    logic [31:0] t_s_reg [3], t_c_reg [3];
    logic [1:0]  quad_reg [3];
    logic [1:0]  qd [CHAIN_LAT+1][3];
    q30_t sn [3], cs [3];
    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_ang
            logic [ANGLE_BITS-1:0] ang;
            logic [31:0] turn;
            assign ang  = s_tdata[16*a +: ANGLE_BITS];
            assign turn = 32'({ang, 32'd0} >> ANGLE_BITS);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    quad_reg[a] <= turn[31:30];
                    t_s_reg[a]  <= {2'b00, turn[29:0]};
                    t_c_reg[a]  <= Q30_ONE - {2'b00, turn[29:0]};
                end
            end
            logic [31:0] s0, c0;
            rpy_sine_chain u_s (.clk(clk), .en(adv), .t(t_s_reg[a]), .sine(s0));
            rpy_sine_chain u_c (.clk(clk), .en(adv), .t(t_c_reg[a]), .sine(c0));
            // Quadrant travels beside the chain.
            assign qd[0][a] = quad_reg[a];
            for (genvar d = 0; d < CHAIN_LAT; d++)
            begin : g_qd
                logic [1:0] q_reg;
                always_ff @(posedge clk)
                    if (adv) q_reg <= qd[d][a];
                assign qd[d+1][a] = q_reg;
            end
            q30_t ss, cc;
            always_comb
            begin
                case (qd[CHAIN_LAT][a])
                    2'd0: begin ss = q30_t'(s0);  cc = q30_t'(c0);  end
                    2'd1: begin ss = q30_t'(c0);  cc = -q30_t'(s0); end
                    2'd2: begin ss = -q30_t'(s0); cc = -q30_t'(c0); end
                    default: begin ss = -q30_t'(c0); cc = q30_t'(s0); end
                endcase
            end
            assign sn[a] = ss;
            assign cs[a] = cc;
        end
    endgenerate

    // Rounded Q2.30 product, half away from zero.
    function automatic q30_t mulq(input q30_t x, input q30_t y);
        logic [63:0] p;
        logic [33:0] m;
        begin
            p = 64'(mag(x)) * 64'(mag(y)) + 64'h2000_0000;
            m = 34'(p >> 30);
            mulq = (x[SIG_W-1] ^ y[SIG_W-1]) ? -q30_t'(m) : q30_t'(m);
        end
    endfunction

    // First products.
    q30_t srsp_reg, crsp_reg, sy_reg, cy_reg, msp_reg;
    q30_t m0_reg, m1_reg, m5_reg, m8_reg, crsy_reg, crcy_reg, srsy_reg, srcy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srsp_reg <= mulq(sn[0], sn[1]);
            crsp_reg <= mulq(cs[0], sn[1]);
            m0_reg   <= mulq(cs[1], cs[2]);
            m1_reg   <= mulq(cs[1], sn[2]);
            m5_reg   <= mulq(sn[0], cs[1]);
            m8_reg   <= mulq(cs[0], cs[1]);
            crsy_reg <= mulq(cs[0], sn[2]);
            crcy_reg <= mulq(cs[0], cs[2]);
            srsy_reg <= mulq(sn[0], sn[2]);
            srcy_reg <= mulq(sn[0], cs[2]);
            msp_reg  <= -sn[1];
            sy_reg   <= sn[2];
            cy_reg   <= cs[2];
        end
    end

    // Second products.
    q30_t p_reg [9];
    q30_t a3_reg, a4_reg, a6_reg, a7_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= m0_reg;  p_reg[1] <= m1_reg;  p_reg[2] <= msp_reg;
            p_reg[3] <= mulq(srsp_reg, cy_reg); a3_reg <= crsy_reg;
            p_reg[4] <= mulq(srsp_reg, sy_reg); a4_reg <= crcy_reg;
            p_reg[5] <= m5_reg;
            p_reg[6] <= mulq(crsp_reg, cy_reg); a6_reg <= srsy_reg;
            p_reg[7] <= mulq(crsp_reg, sy_reg); a7_reg <= srcy_reg;
            p_reg[8] <= m8_reg;
        end
    end

    // Sums.
    q30_t s_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0] <= p_reg[0];
            s_reg[1] <= p_reg[1];
            s_reg[2] <= p_reg[2];
            s_reg[3] <= p_reg[3] - a3_reg;
            s_reg[4] <= p_reg[4] + a4_reg;
            s_reg[5] <= p_reg[5];
            s_reg[6] <= p_reg[6] + a6_reg;
            s_reg[7] <= p_reg[7] - a7_reg;
            s_reg[8] <= p_reg[8];
        end
    end

    // Round to Q1.FRAC_BITS and saturate.
    function automatic logic [OUT_W-1:0] to_out(input q30_t v);
        logic [MAG_W:0] m;
        logic [MAG_W:0] lim;
        logic [MAG_W:0] r;
        begin
            m   = {1'b0, mag(v)};
            lim = (MAG_W+1)'(1) << FRAC_BITS;
            if (FRAC_BITS < 30)
                m = (m + ((MAG_W+1)'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            if (m > lim)
                m = lim;
            r = v[SIG_W-1] ? -m : m;
            to_out = r[OUT_W-1:0];
        end
    endfunction

    logic [143:0] out_reg, out_next;
    always_comb
    begin
        for (int j = 0; j < 9; j++)
            out_next[16*j +: 16] = to_out(s_reg[j]);
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end
    assign m_tdata = out_reg;

    `RPY_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "output word changed while stalled")
    `RPY_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready), "ready mismatch")
    `RPY_ASSERT_NEXT(a_pipe, adv && vld_reg[LAT-2], m_tvalid, "pipeline dropped a word")
endmodule
`default_nettype wire
